// ----- sv/pbla_pkg.sv -----
package pbla_pkg;

  localparam int POINT_LIMIT_DEF = 256;
  localparam int COORD_BITS_DEF  = 24;

  localparam int LEN_W   = 25;
  localparam int ANGLE_W = 16;
  localparam int IDX_W   = 8;

  localparam logic [LEN_W-1:0]   LEN_MAX   = 25'h1FF_FFFF;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'd46080;

  localparam int CORDIC_STEPS = 20;
  localparam int NORM_BITS    = 39;
  localparam int CX_W         = 42;
  localparam int Z_W          = 25;
  localparam int ATAN_W       = 22;

  localparam logic signed [Z_W-1:0] Z_QUARTER = 25'sd5898240;
  localparam logic signed [Z_W-1:0] Z_HALF    = 25'sd11796480;

  typedef struct packed {
    logic       load;
    logic       commit_start;
    logic       mul_en;
    logic [2:0] mul_step;
    logic       unit_start;
    logic       emit;
  } pbla_cmd_t;

  typedef struct packed {
    logic start_path;
    logic full;
    logic units_done;
  } pbla_status_t;

  function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/pbla_sqrt.sv -----
module pbla_sqrt import pbla_pkg::*; #(
  parameter int RW = COORD_BITS_DEF + 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RW-1:0] radicand,
  output logic            busy,
  output logic [RW:0]     root
);

  localparam int CNT_W = $clog2(RW + 1);

  logic [2*RW-1:0]  rad_r, rad_nxt;
  logic [RW+1:0]    rem_r, rem_nxt;
  logic [RW-1:0]    root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [RW+3:0]    rem_sh, trial, diff;

  always_comb begin
    rem_sh   = {rem_r, rad_r[2*RW-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    diff     = rem_sh - trial;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(RW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[2*RW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = diff[RW+1:0];
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[RW+1:0];
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = {1'b0, root_r} + ((rem_r > {2'b00, root_r}) ? (RW+1)'(1) : (RW+1)'(0));

endmodule

// ----- sv/pbla_cordic.sv -----
module pbla_cordic import pbla_pkg::*; #(
  parameter int DW = 2 * COORD_BITS_DEF + 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] dot,
  input  logic signed [DW-1:0] crs,
  output logic                 busy,
  output logic [ANGLE_W-1:0]   angle
);

  localparam int NW = (DW > NORM_BITS) ? DW : NORM_BITS;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_NORM = 2'd1;
  localparam logic [1:0] P_ROT  = 2'd2;
  localparam logic [1:0] P_FIN  = 2'd3;

  logic [1:0]                phase_r, phase_nxt;
  logic [NW-1:0]             a_r, a_nxt, b_r, b_nxt, orv;
  logic                      neg_r, neg_nxt;
  logic signed [CX_W-1:0]    x_r, x_nxt, y_r, y_nxt, negy;
  logic signed [Z_W-1:0]     z_r, z_nxt, zc, theta, atan_s;
  logic [4:0]                i_r, i_nxt;
  logic [ANGLE_W-1:0]        angle_r, angle_nxt;
  logic [DW-1:0]             dot_mag, crs_mag;
  logic [Z_W:0]              rnd;
  logic [Z_W-8:0]            sh;

  always_comb begin
    dot_mag   = dot[DW-1] ? DW'(-dot) : DW'(dot);
    crs_mag   = crs[DW-1] ? DW'(-crs) : DW'(crs);
    orv       = a_r | b_r;
    negy      = -y_r;
    atan_s    = signed'({3'b000, atan_lut(i_r)});
    zc        = (z_r < 0) ? '0 : ((z_r > Z_QUARTER) ? Z_QUARTER : z_r);
    theta     = neg_r ? (Z_HALF - zc) : zc;
    rnd       = {1'b0, theta} + (Z_W+1)'(128);
    sh        = rnd[Z_W:8];
    phase_nxt = phase_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    neg_nxt   = neg_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    i_nxt     = i_r;
    angle_nxt = angle_r;
    case (phase_r)
      P_IDLE: begin
        if (start) begin
          a_nxt     = NW'(dot_mag);
          b_nxt     = NW'(crs_mag);
          neg_nxt   = dot[DW-1];
          phase_nxt = P_NORM;
        end
      end
      P_NORM: begin
        if (orv == '0 || orv[NW-1]) begin
          x_nxt     = signed'({3'b000, a_r[NW-1 -: NORM_BITS]});
          y_nxt     = signed'({3'b000, b_r[NW-1 -: NORM_BITS]});
          z_nxt     = '0;
          i_nxt     = '0;
          phase_nxt = P_ROT;
        end else if (orv[NW-1 -: 8] == '0) begin
          a_nxt = {a_r[NW-9:0], 8'h00};
          b_nxt = {b_r[NW-9:0], 8'h00};
        end else begin
          a_nxt = {a_r[NW-2:0], 1'b0};
          b_nxt = {b_r[NW-2:0], 1'b0};
        end
      end
      P_ROT: begin
        if (y_r > 0) begin
          x_nxt = x_r + (y_r >>> i_r);
          y_nxt = y_r - (x_r >>> i_r);
          z_nxt = z_r + atan_s;
        end else if (y_r < 0) begin
          x_nxt = x_r + (negy >>> i_r);
          y_nxt = y_r + (x_r >>> i_r);
          z_nxt = z_r - atan_s;
        end
        i_nxt = i_r + 1'b1;
        if (i_r == 5'(CORDIC_STEPS - 1)) begin
          phase_nxt = P_FIN;
        end
      end
      P_FIN: begin
        angle_nxt = (sh > (Z_W-7)'(ANGLE_MAX)) ? ANGLE_MAX : sh[ANGLE_W-1:0];
        phase_nxt = P_IDLE;
      end
      default: phase_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    neg_r   <= neg_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    i_r     <= i_nxt;
    angle_r <= angle_nxt;
  end

  assign busy  = (phase_r != P_IDLE);
  assign angle = angle_r;

endmodule

// ----- sv/pbla_dp.sv -----
module pbla_dp import pbla_pkg::*; #(
  parameter int POINT_LIMIT = POINT_LIMIT_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pbla_cmd_t                    cmd,
  output pbla_status_t                 status,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic                         first_point,
  output logic [LEN_W-1:0]             segment_length,
  output logic [ANGLE_W-1:0]           bend_angle,
  output logic [IDX_W-1:0]             segment_index,
  output logic                         degenerate
);

  localparam int CW   = COORD_BITS;
  localparam int DXW  = CW + 1;
  localparam int PW   = 2 * DXW;
  localparam int DW   = PW + 1;
  localparam int CNTW = $clog2(POINT_LIMIT);

  logic signed [CW-1:0]  x_r, y_r, prev_x_r, prev_y_r;
  logic signed [DXW-1:0] dx_r, dy_r, prev_dx_r, prev_dy_r, ma, mb;
  logic                  first_r, have_point_r, prev_zero_r;
  logic [CNTW-1:0]       seg_cnt_r;
  logic signed [PW-1:0]  prod_r, prod_nxt;
  logic [PW-1:0]         sq_r;
  logic signed [DW-1:0]  dot_r, crs_r, prod_ext;
  logic                  sqrt_busy, cordic_busy, zero_now;
  logic [DXW:0]          root;
  logic [ANGLE_W-1:0]    cordic_angle;
  logic [CNTW+IDX_W-1:0] idx_ext;
  logic [LEN_W-1:0]      len_out_r;
  logic [ANGLE_W-1:0]    angle_out_r;
  logic [IDX_W-1:0]      idx_out_r;
  logic                  degen_out_r;

  always_comb begin
    case (cmd.mul_step)
      3'd0:    begin ma = dx_r; mb = dx_r;      end
      3'd1:    begin ma = dy_r; mb = dy_r;      end
      3'd2:    begin ma = dx_r; mb = prev_dx_r; end
      3'd3:    begin ma = dy_r; mb = prev_dy_r; end
      3'd4:    begin ma = dx_r; mb = prev_dy_r; end
      3'd5:    begin ma = dy_r; mb = prev_dx_r; end
      default: begin ma = '0;   mb = '0;        end
    endcase
    prod_nxt = ma * mb;
    prod_ext = DW'(prod_r);
  end

  assign zero_now = (dx_r == '0) && (dy_r == '0);
  assign idx_ext  = (CNTW+IDX_W)'(seg_cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= point_x;
      y_r     <= point_y;
      first_r <= first_point;
      dx_r    <= DXW'(point_x) - DXW'(prev_x_r);
      dy_r    <= DXW'(point_y) - DXW'(prev_y_r);
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
      case (cmd.mul_step)
        3'd1:    sq_r  <= PW'(prod_r);
        3'd2:    sq_r  <= sq_r + PW'(prod_r);
        3'd3:    dot_r <= prod_ext;
        3'd4:    dot_r <= dot_r + prod_ext;
        3'd5:    crs_r <= prod_ext;
        3'd6:    crs_r <= crs_r - prod_ext;
        default: ;
      endcase
    end
    if (cmd.emit) begin
      len_out_r   <= (root > (DXW+1)'(LEN_MAX)) ? LEN_MAX : LEN_W'(root);
      angle_out_r <= (seg_cnt_r == '0 || zero_now || prev_zero_r) ? '0 : cordic_angle;
      idx_out_r   <= idx_ext[IDX_W-1:0];
      degen_out_r <= zero_now || (seg_cnt_r != '0 && prev_zero_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_dx_r    <= '0;
      prev_dy_r    <= '0;
      prev_zero_r  <= 1'b1;
      seg_cnt_r    <= '0;
      have_point_r <= 1'b0;
    end else if (cmd.commit_start) begin
      prev_x_r     <= x_r;
      prev_y_r     <= y_r;
      prev_dx_r    <= '0;
      prev_dy_r    <= '0;
      prev_zero_r  <= 1'b1;
      seg_cnt_r    <= '0;
      have_point_r <= 1'b1;
    end else if (cmd.emit) begin
      prev_x_r    <= x_r;
      prev_y_r    <= y_r;
      prev_dx_r   <= dx_r;
      prev_dy_r   <= dy_r;
      prev_zero_r <= zero_now;
      seg_cnt_r   <= seg_cnt_r + 1'b1;
    end
  end

  pbla_sqrt #(.RW(DXW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.unit_start),
    .radicand (sq_r),
    .busy     (sqrt_busy),
    .root     (root)
  );

  pbla_cordic #(.DW(DW)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.unit_start),
    .dot   (dot_r),
    .crs   (crs_r),
    .busy  (cordic_busy),
    .angle (cordic_angle)
  );

  assign status.start_path = first_r || !have_point_r;
  assign status.full       = (seg_cnt_r >= CNTW'(POINT_LIMIT - 1));
  assign status.units_done = !sqrt_busy && !cordic_busy;

  assign segment_length = len_out_r;
  assign bend_angle     = angle_out_r;
  assign segment_index  = idx_out_r;
  assign degenerate     = degen_out_r;

endmodule

// ----- sv/pbla_ctrl.sv -----
module pbla_ctrl import pbla_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  pbla_status_t status,
  output pbla_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] mstep_r, mstep_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    mstep_nxt    = mstep_r;
    cmd          = '0;
    cmd.mul_step = mstep_r;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        mstep_nxt = '0;
        if (status.start_path) begin
          cmd.commit_start = 1'b1;
          state_nxt        = S_IDLE;
        end else if (status.full) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        mstep_nxt  = mstep_r + 1'b1;
        if (mstep_r == 3'd7) begin
          cmd.unit_start = 1'b1;
          state_nxt      = S_RUN;
        end
      end
      S_RUN: begin
        if (status.units_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mstep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mstep_r     <= mstep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/polyline_length_and_bend_angle_unit.sv -----
// polyline segment length and bend angle
// input words carry one point (in_point_x, in_point_y, signed, 8 fraction
// bits) and in_first_point; a point that opens a path gives no result, each
// later point gives one result word: segment length (25 bits, 8 fraction
// bits, saturating), bend angle to the previous segment (degrees, 8 fraction
// bits), segment index, degenerate flag (this or previous segment zero)
// both channels are valid/ready
// one point is taken at a time; a segment's result is set by the six
// products on the shared multiplier followed by the longer of the
// bit-serial square root and the normalize plus 20-step cordic unit
// points beyond POINT_LIMIT in one path are dropped
// a finished result waits in the output register while the next point is
// accepted; if the receiver stalls, the next result holds until it is taken
// synchronous reset closes the open path and empties the output register
module polyline_length_and_bend_angle_unit import pbla_pkg::*; #(
  parameter int POINT_LIMIT = POINT_LIMIT_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic                         in_first_point,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [LEN_W-1:0]             out_segment_length,
  output logic [ANGLE_W-1:0]           out_bend_angle,
  output logic [IDX_W-1:0]             out_segment_index,
  output logic                         out_degenerate
);

  pbla_cmd_t    cmd;
  pbla_status_t status;

  pbla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pbla_dp #(
    .POINT_LIMIT (POINT_LIMIT),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .point_x        (in_point_x),
    .point_y        (in_point_y),
    .first_point    (in_first_point),
    .segment_length (out_segment_length),
    .bend_angle     (out_bend_angle),
    .segment_index  (out_segment_index),
    .degenerate     (out_degenerate)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("point accepted while previous still in work");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bend_angle <= ANGLE_MAX)
    else $error("bend angle out of range");

  a_degen_no_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_bend_angle == '0)
    else $error("degenerate segment with nonzero angle");

  a_first_no_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_segment_index == '0 |-> out_bend_angle == '0)
    else $error("first segment with nonzero angle");

endmodule

// ----- dv/tb_polyline_length_and_bend_angle_unit.sv -----
module tb_polyline_length_and_bend_angle_unit import pbla_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = COORD_BITS_DEF;
  localparam int MAXP = POINT_LIMIT_DEF;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic first;
  } point_t;

  typedef struct {
    logic [LEN_W-1:0] len;
    logic [ANGLE_W-1:0] angle;
    logic [IDX_W-1:0] idx;
    logic degen;
  } segment_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CB-1:0] in_point_x = '0;
  logic signed [CB-1:0] in_point_y = '0;
  logic in_first_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LEN_W-1:0] out_segment_length;
  logic [ANGLE_W-1:0] out_bend_angle;
  logic [IDX_W-1:0] out_segment_index;
  logic out_degenerate;

  point_t pending_points[$];
  segment_t expected_segments[$];
  int send_idle = 35;
  int recv_idle = 69;
  int fails = 0;
  int cycles = 0;

  // predictor state
  longint last_x, last_y, last_dx, last_dy, last_len;
  int seg_count;
  bit path_open;

  int atan_step[CORDIC_STEPS] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
    29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

  polyline_length_and_bend_angle_unit dut (.*);

  always #5 clk = ~clk;

  function automatic int bit_count(longint unsigned v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  function automatic longint norm_mag(longint unsigned v, int bl);
    if (bl > NORM_BITS) return longint'(v >> (bl - NORM_BITS));
    return longint'(v << (NORM_BITS - bl));
  endfunction

  function automatic longint round_root(longint unsigned s);
    logic [127:0] r, c, rem;
    r = 0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    rem = s - r * r;
    if (rem > r) r = r + 1;
    return longint'(r);
  endfunction

  function automatic longint bend_of(longint dx, longint dy);
    longint dot, crs, cx, cy, nx, z, theta;
    longint unsigned mdot, mcrs;
    int bl;
    dot = dx * last_dx + dy * last_dy;
    crs = dx * last_dy - dy * last_dx;
    mdot = dot < 0 ? -dot : dot;
    mcrs = crs < 0 ? -crs : crs;
    bl = bit_count(mdot) > bit_count(mcrs) ? bit_count(mdot) : bit_count(mcrs);
    cx = norm_mag(mdot, bl);
    cy = norm_mag(mcrs, bl);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (cy > 0) begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        cx = nx;
        z += atan_step[i];
      end else if (cy < 0) begin
        nx = cx + ((-cy) >>> i);
        cy = cy + (cx >>> i);
        cx = nx;
        z -= atan_step[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    theta = dot < 0 ? 180 * 65536 - z : z;
    theta = (theta + 128) >>> 8;
    if (theta > ANGLE_MAX) theta = ANGLE_MAX;
    return theta;
  endfunction

  function automatic void predict_segment(point_t p);
    longint x, y, dx, dy, len, angle;
    segment_t s;
    x = p.x;
    y = p.y;
    if (p.first || !path_open) begin
      last_x = x;
      last_y = y;
      last_dx = 0;
      last_dy = 0;
      last_len = 0;
      seg_count = 0;
      path_open = 1;
      return;
    end
    if (seg_count + 1 >= MAXP) return;
    dx = x - last_x;
    dy = y - last_y;
    len = round_root(longint'(dx * dx + dy * dy));
    angle = 0;
    s.degen = 1'b0;
    if (seg_count == 0) s.degen = (len == 0);
    else if (len == 0 || last_len == 0) s.degen = 1'b1;
    else angle = bend_of(dx, dy);
    s.len = len > LEN_MAX ? LEN_MAX : len[LEN_W-1:0];
    s.angle = angle[ANGLE_W-1:0];
    s.idx = seg_count[IDX_W-1:0];
    expected_segments.push_back(s);
    last_x = x;
    last_y = y;
    last_dx = dx;
    last_dy = dy;
    last_len = len;
    seg_count++;
  endfunction

  // driver
  always @(posedge clk) begin
    point_t p;
    logic give;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      give = in_valid;
      if (in_valid && in_ready) begin
        p.x = in_point_x;
        p.y = in_point_y;
        p.first = in_first_point;
        predict_segment(p);
        give = 1'b0;
      end
      if (!give && pending_points.size() > 0 && $urandom_range(99) >= send_idle) begin
        p = pending_points.pop_front();
        in_point_x <= p.x;
        in_point_y <= p.y;
        in_first_point <= p.first;
        give = 1'b1;
      end
      in_valid <= give;
    end
  end

  // monitor
  always @(posedge clk) begin
    segment_t e;
    cycles++;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_segments.size() == 0) begin
          $error("unexpected result word len=%0d", out_segment_length);
          fails++;
        end else begin
          e = expected_segments.pop_front();
          if (out_segment_length !== e.len) begin
            $error("segment_length exp %0d got %0d", e.len, out_segment_length);
            fails++;
          end
          if (out_bend_angle !== e.angle) begin
            $error("bend_angle exp %0d got %0d", e.angle, out_bend_angle);
            fails++;
          end
          if (out_segment_index !== e.idx) begin
            $error("segment_index exp %0d got %0d", e.idx, out_segment_index);
            fails++;
          end
          if (out_degenerate !== e.degen) begin
            $error("degenerate exp %0d got %0d", e.degen, out_degenerate);
            fails++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_point(longint x, longint y, bit first);
    point_t p;
    p.x = x[CB-1:0];
    p.y = y[CB-1:0];
    p.first = first;
    pending_points.push_back(p);
  endtask

  function automatic longint any_coord();
    return longint'($signed(CB'($urandom)));
  endfunction

  function automatic longint delta();
    case ($urandom_range(3))
      0: return longint'($urandom_range(2000)) - 1000;
      1: return longint'($urandom_range(8)) - 4;
      2: return longint'($urandom_range(200000)) - 100000;
      default: return any_coord();
    endcase
  endfunction

  task automatic random_path(int n, ref int count);
    longint x, y, dx, dy;
    x = any_coord();
    y = any_coord();
    dx = 0;
    dy = 0;
    add_point(x, y, 1'b1);
    count++;
    for (int i = 1; i < n; i++) begin
      case ($urandom_range(9))
        0: begin dx = 0; dy = 0; end
        1: begin dx = dx * 2; dy = dy * 2; end
        2: begin dx = -dx; dy = -dy; end
        3: begin dx = -dy; dy = dx; end
        4: begin x = any_coord(); y = any_coord(); dx = 0; dy = 0; end
        default: begin dx = delta(); dy = delta(); end
      endcase
      x += dx;
      y += dy;
      add_point(x, y, $urandom_range(39) == 0);
      count++;
    end
  endtask

  initial begin
    int count;
    longint mx, mn;
    mx = (1 <<< (CB - 1)) - 1;
    mn = -(1 <<< (CB - 1));
    // point with no open path, then extremes, zero segments, turns, reversal
    add_point(100, 100, 1'b0);
    add_point(100, 100, 1'b0);
    add_point(356, 100, 1'b0);
    add_point(356, 356, 1'b0);
    add_point(100, 356, 1'b0);
    add_point(356, 356, 1'b0);
    add_point(612, 356, 1'b0);
    add_point(1000, 700, 1'b0);
    add_point(1000, 700, 1'b0);
    add_point(mn, mn, 1'b1);
    add_point(mx, mx, 1'b0);
    add_point(mn, mn, 1'b0);
    add_point(mx, mn, 1'b0);
    add_point(mn, mx, 1'b0);
    add_point(0, 0, 1'b1);
    add_point(1, 0, 1'b0);
    add_point(1, 1, 1'b0);
    add_point(mx, 1, 1'b0);
    add_point(mx, mn, 1'b1);
    add_point(mx, mn, 1'b0);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 35 : ph == 1 ? 69 : 0;
      recv_idle = ph == 0 ? 69 : ph == 1 ? 35 : 0;
      count = 0;
      if (ph == 1) begin
        // path that runs past the point limit
        add_point(0, 0, 1'b1);
        for (int i = 1; i < MAXP + 14; i++) add_point(i * 37, (i % 5) * 300, 1'b0);
        count += MAXP + 14;
      end
      while (count < 600) random_path($urandom_range(1, 14), count);
      wait (pending_points.size() == 0 && !in_valid && expected_segments.size() == 0);
      repeat (60) @(posedge clk);
    end
    if (fails == 0 && expected_segments.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- polyline_length_and_bend_angle_unit.f -----
sv/pbla_pkg.sv
sv/pbla_sqrt.sv
sv/pbla_cordic.sv
sv/pbla_dp.sv
sv/pbla_ctrl.sv
sv/polyline_length_and_bend_angle_unit.sv
dv/tb_polyline_length_and_bend_angle_unit.sv
